[design/vtyp_pkg.sv]
// ----------------------------------------------------------------------------
// vtyp_pkg
// Types, widths and the arctangent table of the direction-angle pipeline.
// ----------------------------------------------------------------------------
package vtyp_pkg;

  // field widths
  localparam int unsigned IN_W    = 24;
  localparam int unsigned DIFF_W  = IN_W + 1;
  localparam int unsigned YAW_W   = 17;
  localparam int unsigned PITCH_W = 16;

  // square root: n = (dx*dx + dy*dy) * 4096, one root digit per stage
  localparam int unsigned SQ_W      = 2 * DIFF_W;
  localparam int unsigned SQRT_PAD  = 12;
  localparam int unsigned N_W       = SQ_W + SQRT_PAD;
  localparam int unsigned ROOT_W    = N_W / 2;
  localparam int unsigned REM_W     = ROOT_W + 2;

  // rotation datapath
  localparam int unsigned DIFF_SHIFT       = 30;
  localparam int unsigned H_SHIFT          = 24;
  localparam int unsigned CW               = DIFF_W + DIFF_SHIFT + 3;
  localparam int unsigned Z_W              = 26;
  localparam int unsigned ROUND_SHIFT      = 8;
  localparam int unsigned ANG_W            = Z_W - ROUND_SHIFT;
  localparam int unsigned ANGLE_ITERATIONS = 16;
  localparam int unsigned ATAN_TABLE_SIZE  = 24;
  localparam int unsigned ATAN_IDX_W       = $clog2(ATAN_TABLE_SIZE);

  localparam logic signed [Z_W-1:0] DEG90_FINE = Z_W'(5898240);
  localparam logic signed [Z_W-1:0] ROUND_BIAS = Z_W'(128);
  localparam int                    YAW_LIMIT   = 46080;
  localparam int                    PITCH_LIMIT = 23040;

  // output buffer
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic signed [IN_W-1:0] src_x;
    logic signed [IN_W-1:0] src_y;
    logic signed [IN_W-1:0] src_z;
    logic signed [IN_W-1:0] dst_x;
    logic signed [IN_W-1:0] dst_y;
    logic signed [IN_W-1:0] dst_z;
  } in_t;

  typedef struct packed {
    logic signed [YAW_W-1:0]   yaw;
    logic signed [PITCH_W-1:0] pitch;
    logic                      degenerate;
  } out_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] dz;
  } diff_t;

  typedef struct packed {
    logic [N_W-1:0]    n;
    logic [REM_W-1:0]  r;
    logic [ROOT_W-1:0] q;
    diff_t             diff;
  } sqrt_t;

  typedef struct packed {
    logic signed [CW-1:0]  x;
    logic signed [CW-1:0]  y;
    logic signed [Z_W-1:0] z;
  } lane_t;

  typedef struct packed {
    lane_t yaw;
    lane_t pitch;
    logic  degen;
    logic  dz_zero;
    logic  dz_neg;
  } rot_t;

  // atan(2^-i) in 1/65536 degree, rounded to nearest
  function automatic logic signed [Z_W-1:0] atan_fine(logic [ATAN_IDX_W-1:0] idx);
    logic signed [Z_W-1:0] v;
    unique case (idx)
      5'd0:    v = Z_W'(2949120);
      5'd1:    v = Z_W'(1740967);
      5'd2:    v = Z_W'(919879);
      5'd3:    v = Z_W'(466945);
      5'd4:    v = Z_W'(234379);
      5'd5:    v = Z_W'(117304);
      5'd6:    v = Z_W'(58666);
      5'd7:    v = Z_W'(29335);
      5'd8:    v = Z_W'(14668);
      5'd9:    v = Z_W'(7334);
      5'd10:   v = Z_W'(3667);
      5'd11:   v = Z_W'(1833);
      5'd12:   v = Z_W'(917);
      5'd13:   v = Z_W'(458);
      5'd14:   v = Z_W'(229);
      5'd15:   v = Z_W'(115);
      5'd16:   v = Z_W'(57);
      5'd17:   v = Z_W'(29);
      5'd18:   v = Z_W'(14);
      5'd19:   v = Z_W'(7);
      5'd20:   v = Z_W'(4);
      5'd21:   v = Z_W'(2);
      5'd22:   v = Z_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[design/vector_to_yaw_pitch_core.sv]
// ----------------------------------------------------------------------------
// vector_to_yaw_pitch_core: yaw and pitch of the vector between two points
// difference and square stages, the 31 root-digit stages and one rotation
// stage per iteration; one transaction per cycle while the buffer is not full
// async active-low reset empties pipeline and two-entry output buffer
// ----------------------------------------------------------------------------
module vector_to_yaw_pitch_core import vtyp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  // single advance signal for every stage; the output buffer absorbs the
  // result that leaves the pipe while the consumer is stalled
  logic pipe_en;

  // stage a: differences
  diff_t diff_d, diff_q;
  logic  va_q;

  // stage b: squares
  logic signed [DIFF_W-1:0] dx_a, dy_a;
  logic signed [SQ_W-1:0]   prod_x, prod_y;
  logic [SQ_W-1:0]          sqx_q, sqy_q;
  diff_t                    diffb_q;
  logic                     vb_q;

  // square-root stages, index 0 holds the radicand
  logic [SQ_W-1:0] sq_sum;
  sqrt_t           sqs_d [ROOT_W+1];
  sqrt_t           sqs_q [ROOT_W+1];
  logic [ROOT_W:0] sv_q;

  // rotation stages, index 0 holds the pre-rotated vectors
  rot_t                        cs_d [ANGLE_ITERATIONS+1];
  rot_t                        cs_q [ANGLE_ITERATIONS+1];
  logic [ANGLE_ITERATIONS:0]   cv_q;
  logic signed [CW-1:0]        yx0, yy0;

  // final rounding and clamping
  logic signed [Z_W-1:0]   yz_sum, pz_sum;
  logic signed [ANG_W-1:0] yaw_r, pitch_r, yaw_c;
  logic signed [ANG_W:0]   pitch_n, pitch_c;
  out_t                    res;

  // output buffer
  out_t                  fifo_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                  push, pop;

  function automatic logic signed [CW-1:0] scale_diff(logic signed [DIFF_W-1:0] v);
    return {{(CW - DIFF_W - DIFF_SHIFT){v[DIFF_W-1]}}, v, {DIFF_SHIFT{1'b0}}};
  endfunction

  // one restoring square-root digit
  function automatic sqrt_t sqrt_step(sqrt_t a);
    logic [REM_W+1:0] acc;
    logic [REM_W+1:0] trial;
    sqrt_t            b;
    b     = a;
    acc   = {a.r, a.n[N_W-1 -: 2]};
    trial = (REM_W + 2)'({a.q, 2'b01});
    b.n   = a.n << 2;
    if (acc >= trial) begin
      b.r = REM_W'(acc - trial);
      b.q = {a.q[ROOT_W-2:0], 1'b1};
    end else begin
      b.r = acc[REM_W-1:0];
      b.q = {a.q[ROOT_W-2:0], 1'b0};
    end
    return b;
  endfunction

  // one micro-rotation towards y = 0
  function automatic lane_t micro_rot(lane_t a, logic signed [CW-1:0] xs,
                                      logic signed [CW-1:0] ys,
                                      logic signed [Z_W-1:0] ang);
    lane_t b;
    if (a.y > 0) begin
      b.x = a.x + ys;
      b.y = a.y - xs;
      b.z = a.z + ang;
    end else begin
      b.x = a.x - ys;
      b.y = a.y + xs;
      b.z = a.z - ang;
    end
    return b;
  endfunction

  assign pipe_en    = (cnt_q != FIFO_CNT_W'(FIFO_DEPTH));
  assign in_ready_o = pipe_en;

  // differences, exact in 25 bits
  always_comb begin
    diff_d.dx = {in_data_i.dst_x[IN_W-1], in_data_i.dst_x}
              - {in_data_i.src_x[IN_W-1], in_data_i.src_x};
    diff_d.dy = {in_data_i.dst_y[IN_W-1], in_data_i.dst_y}
              - {in_data_i.src_y[IN_W-1], in_data_i.src_y};
    diff_d.dz = {in_data_i.dst_z[IN_W-1], in_data_i.dst_z}
              - {in_data_i.src_z[IN_W-1], in_data_i.src_z};
  end

  // squares, one multiplier each
  always_comb begin
    dx_a   = diff_q.dx;
    dy_a   = diff_q.dy;
    prod_x = dx_a * dx_a;
    prod_y = dy_a * dy_a;
  end

  // radicand and root digits
  always_comb begin
    sq_sum          = sqx_q + sqy_q;
    sqs_d[0].n      = {sq_sum, SQRT_PAD'(0)};
    sqs_d[0].r      = '0;
    sqs_d[0].q      = '0;
    sqs_d[0].diff   = diffb_q;
    for (int k = 0; k < ROOT_W; k++) begin
      sqs_d[k+1] = sqrt_step(sqs_q[k]);
    end
  end

  // pre-rotation and micro-rotations of both lanes
  always_comb begin
    yx0 = scale_diff(sqs_q[ROOT_W].diff.dx);
    yy0 = scale_diff(sqs_q[ROOT_W].diff.dy);
    // left half plane: turn by a quarter first so the rotations converge
    if (yx0 < 0) begin
      if (yy0 >= 0) begin
        cs_d[0].yaw.x = yy0;
        cs_d[0].yaw.y = -yx0;
        cs_d[0].yaw.z = DEG90_FINE;
      end else begin
        cs_d[0].yaw.x = -yy0;
        cs_d[0].yaw.y = yx0;
        cs_d[0].yaw.z = -DEG90_FINE;
      end
    end else begin
      cs_d[0].yaw.x = yx0;
      cs_d[0].yaw.y = yy0;
      cs_d[0].yaw.z = '0;
    end
    // horizontal distance is never negative, so no pre-rotation here
    cs_d[0].pitch.x = CW'({sqs_q[ROOT_W].q, H_SHIFT'(0)});
    cs_d[0].pitch.y = scale_diff(sqs_q[ROOT_W].diff.dz);
    cs_d[0].pitch.z = '0;
    cs_d[0].degen   = (sqs_q[ROOT_W].diff.dx == '0) && (sqs_q[ROOT_W].diff.dy == '0);
    cs_d[0].dz_zero = (sqs_q[ROOT_W].diff.dz == '0);
    cs_d[0].dz_neg  = sqs_q[ROOT_W].diff.dz[DIFF_W-1];
    for (int i = 0; i < ANGLE_ITERATIONS; i++) begin
      cs_d[i+1]       = cs_q[i];
      cs_d[i+1].yaw   = micro_rot(cs_q[i].yaw, cs_q[i].yaw.x >>> i,
                                  cs_q[i].yaw.y >>> i, atan_fine(ATAN_IDX_W'(i)));
      cs_d[i+1].pitch = micro_rot(cs_q[i].pitch, cs_q[i].pitch.x >>> i,
                                  cs_q[i].pitch.y >>> i, atan_fine(ATAN_IDX_W'(i)));
    end
  end

  // rounding to 1/256 degree (floor of z + 128 over 256) and clamping
  always_comb begin
    yz_sum  = cs_q[ANGLE_ITERATIONS].yaw.z + ROUND_BIAS;
    pz_sum  = cs_q[ANGLE_ITERATIONS].pitch.z + ROUND_BIAS;
    yaw_r   = yz_sum[Z_W-1:ROUND_SHIFT];
    pitch_r = pz_sum[Z_W-1:ROUND_SHIFT];
    pitch_n = -$signed({pitch_r[ANG_W-1], pitch_r});

    if (yaw_r > ANG_W'(YAW_LIMIT)) begin
      yaw_c = ANG_W'(YAW_LIMIT);
    end else if (yaw_r < -ANG_W'(YAW_LIMIT)) begin
      yaw_c = -ANG_W'(YAW_LIMIT);
    end else begin
      yaw_c = yaw_r;
    end

    if (pitch_n > (ANG_W + 1)'(PITCH_LIMIT)) begin
      pitch_c = (ANG_W + 1)'(PITCH_LIMIT);
    end else if (pitch_n < -(ANG_W + 1)'(PITCH_LIMIT)) begin
      pitch_c = -(ANG_W + 1)'(PITCH_LIMIT);
    end else begin
      pitch_c = pitch_n;
    end

    res.degenerate = cs_q[ANGLE_ITERATIONS].degen;
    res.yaw        = cs_q[ANGLE_ITERATIONS].degen ? '0 : yaw_c[YAW_W-1:0];
    // a zero horizontal distance happens exactly when the vector is degenerate
    priority if (cs_q[ANGLE_ITERATIONS].dz_zero) begin
      res.pitch = '0;
    end else if (cs_q[ANGLE_ITERATIONS].degen) begin
      res.pitch = cs_q[ANGLE_ITERATIONS].dz_neg ? PITCH_W'(PITCH_LIMIT)
                                                : -PITCH_W'(PITCH_LIMIT);
    end else begin
      res.pitch = pitch_c[PITCH_W-1:0];
    end
  end

  // output buffer bookkeeping
  assign push        = pipe_en && cv_q[ANGLE_ITERATIONS];
  assign pop         = out_valid_o && out_ready_i;
  assign cnt_d       = cnt_q + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = fifo_q[rd_ptr_q];

  // valid bits and buffer pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q     <= 1'b0;
      vb_q     <= 1'b0;
      sv_q     <= '0;
      cv_q     <= '0;
      cnt_q    <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      if (pipe_en) begin
        va_q <= in_valid_i;
        vb_q <= va_q;
        sv_q <= {sv_q[ROOT_W-1:0], vb_q};
        cv_q <= {cv_q[ANGLE_ITERATIONS-1:0], sv_q[ROOT_W]};
      end
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      diff_q  <= diff_d;
      sqx_q   <= prod_x;
      sqy_q   <= prod_y;
      diffb_q <= diff_q;
      for (int k = 0; k <= ROOT_W; k++) begin
        sqs_q[k] <= sqs_d[k];
      end
      for (int i = 0; i <= ANGLE_ITERATIONS; i++) begin
        cs_q[i] <= cs_d[i];
      end
    end
    if (push) begin
      fifo_q[wr_ptr_q] <= res;
    end
  end

  // a stalled result at the end of the pipe is held, not lost
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!pipe_en && cv_q[ANGLE_ITERATIONS])
      |=> (cv_q[ANGLE_ITERATIONS] && $stable(cs_q[ANGLE_ITERATIONS])))
    else $error("stalled result not held");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("output buffer overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.degenerate)
      |-> (out_data_o.yaw == '0
           && (out_data_o.pitch == '0
               || out_data_o.pitch == PITCH_W'(PITCH_LIMIT)
               || out_data_o.pitch == -PITCH_W'(PITCH_LIMIT))))
    else $error("degenerate transaction with bad angles");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.yaw <= YAW_W'(YAW_LIMIT)
                     && out_data_o.yaw >= -YAW_W'(YAW_LIMIT)
                     && out_data_o.pitch <= PITCH_W'(PITCH_LIMIT)
                     && out_data_o.pitch >= -PITCH_W'(PITCH_LIMIT)))
    else $error("angle out of range");

endmodule
